[hdl/hhfr_pkg.sv]
`default_nettype none

package hhfr_pkg;

  // Offset counter wraps modulo the buffer size, which must be a power of two.
  localparam int BUFFER_BYTES = 65536;
  localparam int OFFSET_W     = $clog2(BUFFER_BYTES);

  localparam int HDR_COUNT = 12;
  localparam int HDR_IDX_W = 4;
  localparam int LPOS_W    = 5;
  localparam int PFX_MAX   = 19;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  typedef enum logic [1:0] {
    KIND_STRING,
    KIND_INT,
    KIND_DATE
  } hdr_kind_t;

  typedef enum logic [1:0] {
    NUM_SKIP,
    NUM_SIGNED,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_t;

  localparam logic [HDR_IDX_W-1:0] HDR_CONTENT_LENGTH    = 4'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_IF_MODIFIED_SINCE = 4'd3;
  localparam logic [HDR_IDX_W-1:0] HDR_STATUS            = 4'd8;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST              = 4'd11;

  // Prefix strings, lower case, right-justified in the vector.
  localparam logic [8*PFX_MAX-1:0] PFX_TEXT [HDR_COUNT] = '{
    "content-length: ", "content-type: ", "user-agent: ",
    "if-modified-since: ", "authorization: ", "referer: ", "cookie: ",
    "location: ", "status: ", "range: ", "connection: ",
    "transfer-encoding: "
  };

  localparam logic [LPOS_W-1:0] PFX_LEN [HDR_COUNT] = '{
    5'd16, 5'd14, 5'd12, 5'd19, 5'd15, 5'd9, 5'd8, 5'd10, 5'd8, 5'd7, 5'd12, 5'd19
  };

  localparam hdr_kind_t PFX_KIND [HDR_COUNT] = '{
    KIND_INT, KIND_STRING, KIND_STRING, KIND_DATE, KIND_STRING, KIND_STRING,
    KIND_STRING, KIND_STRING, KIND_INT, KIND_STRING, KIND_STRING, KIND_STRING
  };

  // Character at a line position of a prefix; zero beyond the longest prefix.
  function automatic logic [7:0] pfx_char(input logic [HDR_IDX_W-1:0] h,
                                          input logic [LPOS_W-1:0] pos);
    logic [8*PFX_MAX-1:0] text;
    logic [7:0] ch;
    text = PFX_TEXT[h] << (8 * (PFX_MAX - int'(PFX_LEN[h])));
    ch = 8'h00;
    if (int'(pos) < PFX_MAX) begin
      ch = text[8*(PFX_MAX-1-int'(pos)) +: 8];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

[hdl/http_header_field_recognizer.sv]
// Channel  Handshake            Payload
// in       in_valid / in_ready  byte_req[7:0], last
// out      out_valid / out_ready header_id[3:0], value_offset[15:0],
//                               value_length[15:0], number[31:0]
//
// One byte is taken per cycle; its result, if any, is in the output register
// on the following cycle. The per-byte work is the twelve prefix comparators
// and one multiply-by-ten step of the decimal accumulator.
// in_ready stays high while the output register is empty or being drained,
// so a stalled result holds only the input side, and only while it waits.
// Synchronous reset returns all line state and the offset counter to idle.

`default_nettype none

module http_header_field_recognizer
  import hhfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_req,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       header_id,
  output logic [15:0]      value_offset,
  output logic [15:0]      value_length,
  output logic [31:0]      number
);

  logic [OFFSET_W-1:0]  byte_offset, byte_offset_next;
  logic [LPOS_W-1:0]    line_position, line_position_next;
  logic [HDR_COUNT-1:0] match_mask, match_mask_next;
  logic [HDR_IDX_W-1:0] matched_index, matched_index_next;
  logic                 matched_flag, matched_flag_next;
  logic [OFFSET_W-1:0]  value_start, value_start_next;
  logic [7:0]           previous_byte, previous_byte_next;
  logic [31:0]          accumulator, accumulator_next;
  num_phase_t           number_phase, number_phase_next;
  logic                 negative_flag, negative_flag_next;
  logic                 overflow_flag, overflow_flag_next;

  logic                 accept;
  logic                 is_newline;
  logic [OFFSET_W-1:0]  next_off;
  logic [7:0]           folded;
  logic                 feed_en;
  logic                 is_blank;
  logic                 is_digit;
  logic [35:0]          product;

  num_phase_t           feed_phase;
  logic [31:0]          feed_acc;
  logic                 feed_neg;
  logic                 feed_ovf;

  logic [HDR_COUNT-1:0] cmp_mask;
  logic                 cmp_hit;
  logic [HDR_IDX_W-1:0] cmp_idx;

  logic                 emit;
  logic [OFFSET_W-1:0]  end_off;
  logic [7:0]           last_value_byte;
  logic [OFFSET_W-1:0]  len;
  hdr_kind_t            kind;
  logic [3:0]           res_id;
  logic [15:0]          res_offset;
  logic [15:0]          res_length;
  logic [31:0]          res_number;

  assign in_ready   = !out_valid || out_ready;
  assign accept     = in_valid && in_ready;
  assign is_newline = (byte_req == CH_LF);
  assign next_off   = byte_offset + OFFSET_W'(1);
  assign folded     = (byte_req >= CH_UPPER_A && byte_req <= CH_UPPER_Z) ?
                      byte_req + 8'h20 : byte_req;
  assign kind       = PFX_KIND[matched_index];
  assign feed_en    = matched_flag && !is_newline && (kind == KIND_INT);
  assign is_blank   = (byte_req == CH_SPACE) || (byte_req == CH_TAB) ||
                      (byte_req == CH_VT) || (byte_req == CH_FF) || (byte_req == CH_CR);
  assign is_digit   = (byte_req >= CH_ZERO) && (byte_req <= CH_NINE);
  assign product    = ({4'b0, accumulator} << 3) + ({4'b0, accumulator} << 1) +
                      36'(byte_req - CH_ZERO);

  // Decimal parser: values after this byte; unchanged when not fed.
  always_comb begin
    feed_phase = number_phase;
    feed_acc   = accumulator;
    feed_neg   = negative_flag;
    feed_ovf   = overflow_flag;
    if (feed_en) begin
      unique case (number_phase)
        NUM_SKIP: begin
          if (is_blank) begin
            feed_phase = NUM_SKIP;
          end else if (byte_req == CH_PLUS || byte_req == CH_MINUS) begin
            feed_neg   = (byte_req == CH_MINUS);
            feed_phase = NUM_SIGNED;
          end else if (!is_digit) begin
            feed_phase = NUM_DONE;
          end else begin
            feed_phase = NUM_DIGITS;
            if (!overflow_flag) begin
              if (product[35:32] != 4'd0) feed_ovf = 1'b1;
              else feed_acc = product[31:0];
            end
          end
        end
        NUM_SIGNED, NUM_DIGITS: begin
          if (!is_digit) begin
            feed_phase = NUM_DONE;
          end else begin
            feed_phase = NUM_DIGITS;
            if (!overflow_flag) begin
              if (product[35:32] != 4'd0) feed_ovf = 1'b1;
              else feed_acc = product[31:0];
            end
          end
        end
        NUM_DONE: begin
          feed_phase = NUM_DONE;
        end
        default: begin
          feed_phase = number_phase;
        end
      endcase
    end
  end

  // Twelve prefix comparators; the lowest index completing here wins.
  always_comb begin
    cmp_mask = match_mask;
    cmp_hit  = 1'b0;
    cmp_idx  = '0;
    for (int h = 0; h < HDR_COUNT; h++) begin
      cmp_mask[h] = match_mask[h] && (line_position < PFX_LEN[h]) &&
                    (pfx_char(HDR_IDX_W'(h), line_position) == folded);
      if (cmp_mask[h] && (line_position == PFX_LEN[h] - 5'd1) && !cmp_hit) begin
        cmp_hit = 1'b1;
        cmp_idx = HDR_IDX_W'(h);
      end
    end
  end

  // Result for a recognized line, closed by newline or by the buffer end.
  always_comb begin
    emit            = matched_flag && (is_newline || last);
    end_off         = is_newline ? byte_offset : next_off;
    last_value_byte = is_newline ? previous_byte : byte_req;
    len             = end_off - value_start;
    if (len != '0 && last_value_byte == CH_CR) begin
      len = len - OFFSET_W'(1);
    end
    res_id     = matched_index;
    res_offset = 16'(value_start);
    res_length = 16'(len);
    res_number = '0;
    if (kind == KIND_INT) begin
      if (feed_ovf) res_number = '1;
      else if (feed_neg) res_number = 32'd0 - feed_acc;
      else res_number = feed_acc;
    end
    if (kind == KIND_DATE) begin
      res_offset = '0;
      res_length = '0;
      res_number = '0;
    end
  end

  always_comb begin
    byte_offset_next   = next_off;
    line_position_next = line_position;
    match_mask_next    = match_mask;
    matched_index_next = matched_index;
    matched_flag_next  = matched_flag;
    value_start_next   = value_start;
    previous_byte_next = byte_req;
    accumulator_next   = feed_acc;
    number_phase_next  = feed_phase;
    negative_flag_next = feed_neg;
    overflow_flag_next = feed_ovf;
    if (!matched_flag && !is_newline) begin
      match_mask_next = cmp_mask;
      if (cmp_hit && !last) begin
        matched_flag_next  = 1'b1;
        matched_index_next = cmp_idx;
        value_start_next   = next_off;
      end
      if (line_position != '1) begin
        line_position_next = line_position + LPOS_W'(1);
      end
    end
    if (is_newline || last) begin
      line_position_next = '0;
      match_mask_next    = '1;
      matched_index_next = '0;
      matched_flag_next  = 1'b0;
      value_start_next   = '0;
      previous_byte_next = '0;
      accumulator_next   = '0;
      number_phase_next  = NUM_SKIP;
      negative_flag_next = 1'b0;
      overflow_flag_next = 1'b0;
    end
    if (last) begin
      byte_offset_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      line_position <= '0;
      match_mask    <= '1;
      matched_index <= '0;
      matched_flag  <= 1'b0;
      value_start   <= '0;
      previous_byte <= '0;
      accumulator   <= '0;
      number_phase  <= NUM_SKIP;
      negative_flag <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      byte_offset   <= byte_offset_next;
      line_position <= line_position_next;
      match_mask    <= match_mask_next;
      matched_index <= matched_index_next;
      matched_flag  <= matched_flag_next;
      value_start   <= value_start_next;
      previous_byte <= previous_byte_next;
      accumulator   <= accumulator_next;
      number_phase  <= number_phase_next;
      negative_flag <= negative_flag_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      header_id    <= res_id;
      value_offset <= res_offset;
      value_length <= res_length;
      number       <= res_number;
    end
  end

endmodule

`default_nettype wire

[hdl/hhfr_checker.sv]
`default_nettype none

module hhfr_checker
  import hhfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  byte_req,
  input wire logic        last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  header_id,
  input wire logic [15:0] value_offset,
  input wire logic [15:0] value_length,
  input wire logic [31:0] number
);

  // A waiting result keeps its contents until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(header_id) &&
    $stable(value_offset) && $stable(value_length) && $stable(number))
    else $error("result changed while stalled");

  // A fresh result only ever follows an accepted byte.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(in_valid && in_ready) |-> $past(out_valid && !out_ready))
    else $error("result without an accepted byte");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> header_id <= HDR_LAST)
    else $error("header index out of range");

  a_date_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_id == HDR_IF_MODIFIED_SINCE |->
    value_offset == 16'd0 && value_length == 16'd0 && number == 32'd0)
    else $error("date header carries value fields");

  a_string_no_number: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_id != HDR_CONTENT_LENGTH && header_id != HDR_STATUS |->
    number == 32'd0)
    else $error("non-integer header carries a number");

endmodule

bind http_header_field_recognizer hhfr_checker u_hhfr_checker (.*);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import hhfr_pkg::*;

  localparam int RANDOM_BYTES = 1900;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [3:0]  header_id;
    logic [15:0] value_offset;
    logic [15:0] value_length;
    logic [31:0] number;
  } field_result_t;

  // Tracks the line state of the header buffer and queues the field results
  // the block must produce, in order.
  class header_line_tracker;
    string         prefix_text [HDR_COUNT];
    logic [15:0]   offset;
    logic [15:0]   vstart;
    logic [4:0]    lpos;
    logic [11:0]   mask;
    logic [3:0]    idx;
    logic          matched;
    logic          neg;
    logic          ovf;
    logic [7:0]    prev_byte;
    logic [31:0]   acc;
    num_phase_t    phase;
    field_result_t due_fields [$];
    int            mismatch_count;

    function new();
      prefix_text = '{
        "content-length: ", "content-type: ", "user-agent: ",
        "if-modified-since: ", "authorization: ", "referer: ", "cookie: ",
        "location: ", "status: ", "range: ", "connection: ",
        "transfer-encoding: "
      };
      mismatch_count = 0;
      offset = '0;
      clear_line();
    endfunction

    function hdr_kind_t kind_of(logic [3:0] h);
      if (h == HDR_CONTENT_LENGTH || h == HDR_STATUS) return KIND_INT;
      if (h == HDR_IF_MODIFIED_SINCE) return KIND_DATE;
      return KIND_STRING;
    endfunction

    function void clear_line();
      lpos = '0;
      mask = '1;
      idx = '0;
      matched = 1'b0;
      vstart = '0;
      prev_byte = '0;
      acc = '0;
      phase = NUM_SKIP;
      neg = 1'b0;
      ovf = 1'b0;
    endfunction

    function void take_number_char(logic [7:0] c);
      logic [35:0] prod;
      logic blank;
      logic digit;
      blank = (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR);
      digit = (c >= CH_ZERO && c <= CH_NINE);
      if (phase == NUM_SKIP) begin
        if (blank) return;
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg = (c == CH_MINUS);
          phase = NUM_SIGNED;
          return;
        end
        phase = NUM_SIGNED;
      end
      if (phase == NUM_SIGNED || phase == NUM_DIGITS) begin
        if (!digit) begin
          phase = NUM_DONE;
          return;
        end
        phase = NUM_DIGITS;
        if (!ovf) begin
          prod = {4'b0, acc} * 36'd10 + 36'(c - CH_ZERO);
          if (prod[35:32] != 4'd0) ovf = 1'b1;
          else acc = prod[31:0];
        end
      end
    endfunction

    function void push_result(logic [15:0] end_off, logic [7:0] tail);
      field_result_t r;
      logic [15:0] span;
      span = end_off - vstart;
      if (span != 16'd0 && tail == CH_CR) span = span - 16'd1;
      r = '0;
      r.header_id = idx;
      if (kind_of(idx) != KIND_DATE) begin
        r.value_offset = vstart;
        r.value_length = span;
        if (kind_of(idx) == KIND_INT) r.number = ovf ? 32'hFFFF_FFFF : (neg ? -acc : acc);
      end
      due_fields.push_back(r);
    endfunction

    function void take_byte(logic [7:0] c, logic fin);
      logic [15:0] next_off;
      logic [7:0] lc;
      next_off = offset + 16'd1;
      if (c == CH_LF) begin
        if (matched) push_result(offset, prev_byte);
        clear_line();
      end else if (matched) begin
        if (kind_of(idx) == KIND_INT) take_number_char(c);
        prev_byte = c;
        if (fin) push_result(next_off, c);
      end else begin
        lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'h20 : c;
        for (int h = 0; h < HDR_COUNT; h++) begin
          if (!mask[h]) continue;
          if (lpos >= prefix_text[h].len() || 8'(prefix_text[h][lpos]) != lc) begin
            mask[h] = 1'b0;
            continue;
          end
          // A prefix ending on the final byte of the buffer does not count.
          if (lpos + 1 == prefix_text[h].len() && !fin && !matched) begin
            matched = 1'b1;
            idx = 4'(h);
            vstart = next_off;
          end
        end
        prev_byte = c;
        if (lpos != 5'd31) lpos = lpos + 5'd1;
      end
      if (fin) begin
        offset = '0;
        clear_line();
      end else begin
        offset = next_off;
      end
    endfunction

    function void check_one(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: %s got %0d, expected %0d", $realtime, name, got, want);
      end
    endfunction

    function void match_result(field_result_t got);
      field_result_t want;
      if (due_fields.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with header_id %0d arrived with nothing due",
                   $realtime, got.header_id);
        return;
      end
      want = due_fields.pop_front();
      check_one("header_id", 32'(got.header_id), 32'(want.header_id));
      check_one("value_offset", 32'(got.value_offset), 32'(want.value_offset));
      check_one("value_length", 32'(got.value_length), 32'(want.value_length));
      check_one("number", got.number, want.number);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_req = 8'h00;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  header_id;
  logic [15:0] value_offset;
  logic [15:0] value_length;
  logic [31:0] number;

  header_line_tracker tracker = new();
  logic [7:0]    buf_q [$];
  field_result_t seen;
  bit            no_gaps = 1'b0;
  bit            long_hold = 1'b0;

  http_header_field_recognizer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_req     (byte_req),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .header_id    (header_id),
    .value_offset (value_offset),
    .value_length (value_length),
    .number       (number)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tracker.take_byte(byte_req, last);
    if (!rst && out_valid && out_ready) begin
      seen = '{header_id, value_offset, value_length, number};
      tracker.match_result(seen);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_sink
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) buf_q.push_back(8'(s[i]));
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0: return CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      3: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // Random bytes up to max_len, never a newline so the line stays open.
  function automatic void add_filler(int max_len, bit printable);
    logic [7:0] ch;
    repeat ($urandom_range(0, max_len)) begin
      if (printable && $urandom_range(0, 9) != 0) ch = 8'($urandom_range(32, 126));
      else ch = 8'($urandom_range(0, 255));
      if (ch == CH_LF) ch = printable ? CH_CR : 8'hFF;
      buf_q.push_back(ch);
    end
  endfunction

  function automatic void add_eol();
    case ($urandom_range(0, 9))
      0, 1: buf_q.push_back(CH_LF);
      2: begin
        buf_q.push_back(CH_CR);
        buf_q.push_back(CH_CR);
        buf_q.push_back(CH_LF);
      end
      default: begin
        buf_q.push_back(CH_CR);
        buf_q.push_back(CH_LF);
      end
    endcase
  endfunction

  function automatic void add_prefix(int h);
    string p;
    logic [7:0] ch;
    p = tracker.prefix_text[h];
    for (int i = 0; i < p.len(); i++) begin
      ch = 8'(p[i]);
      if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) ch = ch - 8'h20;
      buf_q.push_back(ch);
    end
  endfunction

  function automatic void add_number_value();
    string digits;
    repeat ($urandom_range(0, 2)) buf_q.push_back(pick_blank());
    case ($urandom_range(0, 3))
      0: buf_q.push_back(CH_PLUS);
      1: buf_q.push_back(CH_MINUS);
      default: ;
    endcase
    digits = "";
    case ($urandom_range(0, 6))
      0, 1: digits = $sformatf("%0d", $urandom_range(0, 999));
      2: digits = $sformatf("%0d", $urandom());
      3: digits = "4294967295";
      4: digits = "4294967296";
      5: repeat ($urandom_range(11, 20)) digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
      default: ;
    endcase
    add_text(digits);
    if ($urandom_range(0, 4) == 0) add_filler(8, 1'b1);
  endfunction

  function automatic void add_header_line(int h, bit close);
    add_prefix(h);
    if (tracker.kind_of(4'(h)) == KIND_INT) add_number_value();
    else add_filler(24, 1'b1);
    if (close) add_eol();
  endfunction

  // A prefix cut short, sometimes with its last kept character altered.
  function automatic void add_broken_prefix();
    string p;
    int cut;
    p = tracker.prefix_text[$urandom_range(0, HDR_LAST)];
    cut = $urandom_range(1, p.len() - 1);
    for (int i = 0; i < cut; i++) buf_q.push_back(8'(p[i]));
    if ($urandom_range(0, 1) == 1) buf_q[buf_q.size() - 1] = 8'($urandom_range(33, 126));
    add_filler(12, 1'b1);
  endfunction

  function automatic void build_random_buffer();
    int lines;
    int r;
    bit close;
    lines = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) buf_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    for (int k = 0; k < lines; k++) begin
      close = (k < lines - 1) || ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        add_header_line($urandom_range(0, HDR_LAST), close);
      end else if (r < 68) begin
        // Buffer ends on the prefix itself or one byte after it.
        add_prefix($urandom_range(0, HDR_LAST));
        if ($urandom_range(0, 1) == 1) buf_q.push_back(8'($urandom_range(0, 255)));
        return;
      end else if (r < 78) begin
        add_broken_prefix();
        if (close) add_eol();
      end else if (r < 92) begin
        add_filler(45, 1'b0);
        if (close) add_eol();
      end else if (close) begin
        add_eol();
      end
    end
    if (buf_q.size() == 0) buf_q.push_back(CH_LF);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_req <= b;
    last <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < buf_q.size(); i++) send_byte(buf_q[i], i == buf_q.size() - 1);
    buf_q.delete();
  endtask

  // Called at the clock edge of the last transfer; valid drops there.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_fields.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int sent;
    bit held;
    bit paused;
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    buf_q.push_back(8'h00);
    send_buffer();
    add_text("RANGE: ");
    buf_q.push_back(8'hFF);
    send_buffer();
    add_text("status: ");
    send_buffer();
    add_text("status: -7");
    buf_q.push_back(CH_CR);
    buf_q.push_back(CH_LF);
    send_buffer();

    while (sent < RANDOM_BYTES) begin
      if (!held && sent > 600) begin
        // Results back up behind a stalled receiver while bytes keep coming.
        held = 1'b1;
        long_hold = 1'b1;
        no_gaps = 1'b1;
        repeat (10) add_header_line($urandom_range(0, HDR_LAST), 1'b1);
        sent += buf_q.size();
        send_buffer();
      end
      if (!paused && sent > 1100) begin
        // The sender waits here until every expected result has come out.
        paused = 1'b1;
        wait_drained();
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      build_random_buffer();
      sent += buf_q.size();
      send_buffer();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.due_fields.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/hhfr_pkg.sv
hdl/http_header_field_recognizer.sv
hdl/hhfr_checker.sv
sim/tb.sv
